// ===== design/npcm_pkg.sv =====
// shared types and constants of the nearest palette color mapper
`default_nettype none

package npcm_pkg;

  // default palette capacity
  localparam int unsigned PaletteMaxDef = 256;
  // palette_index range caps the number of cells
  localparam int unsigned IndexW  = 8;
  localparam int unsigned IndexLim = 256;
  localparam int unsigned CountW  = 9;
  localparam int unsigned ColorW  = 32;
  // largest squared rgba distance is 4 * 255 * 255, fits 18 bits
  localparam int unsigned DistW   = 18;

  // tuser codes of the input stream
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_e;

  // pixel record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              pass;
    logic [ColorW-1:0] pixel;
    logic [DistW-1:0]  best_d;
    logic [IndexW-1:0] best_i;
    logic [ColorW-1:0] best_c;
  } stage_t;

endpackage

`default_nettype wire

// ===== design/npcm_cell.sv =====
// one palette cell: holds one entry and updates the passing pixel record
`default_nettype none

module npcm_cell
  import npcm_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              load_en_i,
  input  wire logic [IndexW-1:0] load_idx_i,
  input  wire logic [ColorW-1:0] load_color_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire stage_t            stage_i,
  output stage_t                 stage_o
);

  logic [ColorW-1:0] entry_q;
  stage_t            stage_q, stage_d;
  logic              active;
  logic              hit;
  logic [DistW-1:0]  sq_dist;

  // squared distance of one 8-bit channel
  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  // palette entry, written by a load transfer to this slot
  always_ff @(posedge clk_i) begin
    if (load_en_i && (load_idx_i == IndexW'(CellIdx))) begin
      entry_q <= load_color_i;
    end
  end

  assign active  = (CountW'(CellIdx) < count_i);
  assign hit     = (entry_q == stage_i.pixel) ||
                   ((entry_q[31:24] == 8'h00) && (stage_i.pixel[31:24] == 8'h00));
  assign sq_dist = DistW'(chan_sq(entry_q[7:0],   stage_i.pixel[7:0]))   +
                   DistW'(chan_sq(entry_q[15:8],  stage_i.pixel[15:8]))  +
                   DistW'(chan_sq(entry_q[23:16], stage_i.pixel[23:16])) +
                   DistW'(chan_sq(entry_q[31:24], stage_i.pixel[31:24]));

  // compare step: exact or transparent hit ends the search, else keep the nearer
  always_comb begin
    stage_d = stage_i;
    if (stage_i.valid && !stage_i.done && !stage_i.pass && active) begin
      if (hit) begin
        stage_d.done   = 1'b1;
        stage_d.best_i = IndexW'(CellIdx);
        stage_d.best_c = entry_q;
      end else if (sq_dist < stage_i.best_d) begin
        stage_d.best_d = sq_dist;
        stage_d.best_i = IndexW'(CellIdx);
        stage_d.best_c = entry_q;
      end
    end
  end

  // record register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== design/nearest_palette_color_mapper.sv =====
// top level: palette loading, cell chain and output stream of the color mapper
//
// Usage. The slave stream carries commands: tuser 0 loads tdata's color into
// the palette slot given by entry_index, tuser 1 maps the pixel in tdata.
// A load transfer gives no result; each map transfer gives one result on the
// master stream: the chosen palette index and color, with tuser set when the
// palette is empty and the pixel is returned unchanged.
// The palette count is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, which the block itself does not enforce. Pixels
// run through a chain of min(PALETTE_MAX, 256) cells, one cell per palette
// entry; the last cell's register is the output register, so a pixel passes
// through every cell's register before it appears at the master side. One
// pixel may enter every cycle while the master side does not stall. A load
// waits until every pixel in the chain has been delivered. When the receiver
// stalls, the whole chain holds and the slave side is not ready until the
// output register is taken. Reset empties the chain and sets the count to
// zero; palette contents are undefined until loaded.
`default_nettype none

module nearest_palette_color_mapper
  import npcm_pkg::*;
#(
  parameter int unsigned PALETTE_MAX = PaletteMaxDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: palette_count
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i,
  // input stream
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // [7:0] entry_index, [39:8] color_rgba
  input  wire logic              s_axis_tuser,  // [0] command
  // output stream
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output      logic [39:0]       m_axis_tdata,  // [7:0] palette_index, [39:8] mapped_rgba
  output      logic              m_axis_tuser   // [0] passed_through
);

  localparam int unsigned NCell = (PALETTE_MAX < IndexLim) ? PALETTE_MAX : IndexLim;
  localparam int unsigned FlyW  = $clog2(NCell + 1);

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_eff;
  logic [FlyW-1:0]   fly_q, fly_d;
  logic              adv;
  logic              in_xfer, out_xfer;
  logic              map_xfer, load_xfer;
  cmd_e              cmd;
  stage_t            chain [NCell+1];

  assign cmd = cmd_e'(s_axis_tuser);

  // count register; count_eff saturates it to the number of cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign count_eff = (count_q > CountW'(NCell)) ? CountW'(NCell) : count_q;

  // chain advances whenever the output register is free or being taken
  assign adv           = !chain[NCell].valid || m_axis_tready;
  assign s_axis_tready = adv && ((cmd == CMD_MAP) || (fly_q == '0));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign map_xfer      = in_xfer && (cmd == CMD_MAP);
  assign load_xfer     = in_xfer && (cmd == CMD_LOAD);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // pixels between input and output transfer
  always_comb begin
    fly_d = fly_q;
    unique case ({map_xfer, out_xfer})
      2'b10:   fly_d = fly_q + FlyW'(1);
      2'b01:   fly_d = fly_q - FlyW'(1);
      default: fly_d = fly_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q <= '0;
    end else begin
      fly_q <= fly_d;
    end
  end

  // record entering the first cell
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = map_xfer;
    chain[0].pass   = (count_eff == '0);
    chain[0].pixel  = s_axis_tdata[39:8];
    chain[0].best_d = '1;
  end

  // row of palette cells
  for (genvar j = 0; j < NCell; j++) begin : g_cell
    npcm_cell #(
      .CellIdx(j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .load_en_i   (load_xfer),
      .load_idx_i  (s_axis_tdata[7:0]),
      .load_color_i(s_axis_tdata[39:8]),
      .count_i     (count_eff),
      .stage_i     (chain[j]),
      .stage_o     (chain[j+1])
    );
  end

  // output from the last cell's register
  assign m_axis_tvalid      = chain[NCell].valid;
  assign m_axis_tuser       = chain[NCell].pass;
  assign m_axis_tdata[7:0]  = chain[NCell].pass ? '0 : chain[NCell].best_i;
  assign m_axis_tdata[39:8] = chain[NCell].pass ? chain[NCell].pixel : chain[NCell].best_c;

  // a result only while a pixel is counted in flight
  a_out_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fly_q != '0))
    else $error("output valid with no pixel in flight");

  // the chain never holds more pixels than it has cells
  a_fly_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fly_q <= FlyW'(NCell))
    else $error("in-flight count exceeds chain length");

  // a searched result needs a non-empty palette
  a_search_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (count_eff != '0))
    else $error("searched result with empty palette");

  // a load transfer leaves the chain empty
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> !m_axis_tvalid)
    else $error("load taken with pixels in the chain");

endmodule

`default_nettype wire
